@@ hdl/space_curve_curvature_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the space curve curvature core
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPACE_CURVE_CURVATURE_CORE_DEFINES_SVH
`define SPACE_CURVE_CURVATURE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCC_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/scc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space curve curvature package
// Widths and pipeline latencies shared by the curvature datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int COMP_W  = 32;
  localparam int CMAG_W  = 63;
  localparam int NORM_W  = 64;
  localparam int SUMSQ_W = 128;
  localparam int SPEED_W = 32;
  localparam int ROOT_W  = 64;
  localparam int CUBE_W  = 96;
  localparam int QUOT_W  = 32;
  localparam int MINS_W  = 16;

  localparam int LAT_FRONT = 3;
  localparam int LAT_SQRTN = NORM_W / 2;
  localparam int LAT_CUBE  = 3;
  localparam int LAT_SQSUM = 3;
  localparam int LAT_SQRTS = SUMSQ_W / 2;
  localparam int LAT_DIV   = QUOT_W;

  localparam int T_SPEED = LAT_FRONT + LAT_SQRTN;
  localparam int T_CUBE  = T_SPEED + LAT_CUBE;
  localparam int T_ROOT  = LAT_FRONT + LAT_SQSUM + LAT_SQRTS;
  localparam int T_DIV   = T_ROOT + LAT_DIV;

  localparam int DLY_CUBE  = T_ROOT - T_CUBE;
  localparam int DLY_SPEED = T_DIV - T_SPEED;
  localparam int PIPE_LAT  = T_DIV;

endpackage

@@ hdl/scc_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line
// Shift register that keeps side data aligned with the long datapath.
// ----------------------------------------------------------------------------
module scc_delay #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

@@ hdl/scc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front products
// Squared norm of the first derivative and cross product magnitudes.
// ----------------------------------------------------------------------------
module scc_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [scc_pkg::COMP_W-1:0]    fx,
  input  logic signed [scc_pkg::COMP_W-1:0]    fy,
  input  logic signed [scc_pkg::COMP_W-1:0]    fz,
  input  logic signed [scc_pkg::COMP_W-1:0]    gx,
  input  logic signed [scc_pkg::COMP_W-1:0]    gy,
  input  logic signed [scc_pkg::COMP_W-1:0]    gz,
  output logic [scc_pkg::NORM_W-1:0]           norm,
  output logic [2:0][scc_pkg::CMAG_W-1:0]      cmag
);

  logic signed [63:0] sq_x, sq_y, sq_z;
  logic signed [63:0] pa [3];
  logic signed [63:0] pb [3];
  logic [scc_pkg::NORM_W-1:0] norm_s2;
  logic signed [63:0] cr [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= fx * fx;
      sq_y  <= fy * fy;
      sq_z  <= fz * fz;
      pa[0] <= fy * gz;
      pb[0] <= fz * gy;
      pa[1] <= fz * gx;
      pb[1] <= fx * gz;
      pa[2] <= fx * gy;
      pb[2] <= fy * gx;

      norm_s2 <= 64'(unsigned'(sq_x)) + 64'(unsigned'(sq_y)) + 64'(unsigned'(sq_z));
      for (int i = 0; i < 3; i++) begin
        cr[i] <= pa[i] - pb[i];
      end

      norm <= norm_s2;
      for (int i = 0; i < 3; i++) begin
        cmag[i] <= cr[i][63] ? 63'(-cr[i]) : cr[i][62:0];
      end
    end
  end

endmodule

@@ hdl/scc_sqsum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross product squared length
// Sum of squares of three 63-bit magnitudes from 32-bit partial products.
// ----------------------------------------------------------------------------
module scc_sqsum (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [2:0][scc_pkg::CMAG_W-1:0]      cmag,
  output logic [scc_pkg::SUMSQ_W-1:0]          sumsq
);

  logic [61:0]  hh [3];
  logic [62:0]  hl [3];
  logic [63:0]  ll [3];
  logic [125:0] sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= cmag[i][62:32] * cmag[i][62:32];
        hl[i] <= cmag[i][62:32] * cmag[i][31:0];
        ll[i] <= cmag[i][31:0] * cmag[i][31:0];
      end
      for (int i = 0; i < 3; i++) begin
        sq[i] <= {hh[i], 64'b0} + {30'b0, hl[i], 33'b0} + {62'b0, ll[i]};
      end
      sumsq <= {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
    end
  end

endmodule

@@ hdl/scc_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor of the square root of a W-bit value.
// ----------------------------------------------------------------------------
module scc_isqrt #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     x,
  output logic [W/2-1:0]   root
);

  localparam int RW = W / 2;

  logic [W-1:0]  rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [W-1:0]  rem_in;
    logic [RW-1:0] root_in;
    logic [W-1:0]  inc;

    if (k == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign inc = ({{RW{1'b0}}, root_in} << (B + 1)) | ({{(W-1){1'b0}}, 1'b1} << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= inc) begin
          rem_q[k]  <= rem_in - inc;
          root_q[k] <= root_in | ({{(RW-1){1'b0}}, 1'b1} << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

@@ hdl/scc_cube.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed cube
// Cube of the 32-bit speed built from 32 by 32 products.
// ----------------------------------------------------------------------------
module scc_cube (
  input  logic                          clk,
  input  logic                          en,
  input  logic [scc_pkg::SPEED_W-1:0]   speed,
  output logic [scc_pkg::CUBE_W-1:0]    cube
);

  logic [63:0] sq;
  logic [31:0] s1;
  logic [63:0] plo, phi;

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= speed * speed;
      s1   <= speed;
      plo  <= sq[31:0] * s1;
      phi  <= sq[63:32] * s1;
      cube <= {phi, 32'b0} + {32'b0, plo};
    end
  end

endmodule

@@ hdl/scc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division with one quotient bit per stage and overflow detect.
// ----------------------------------------------------------------------------
module scc_div #(
  parameter int XW = 96
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [XW-1:0]                 x,
  input  logic [scc_pkg::CUBE_W-1:0]    d,
  output logic [scc_pkg::QUOT_W-1:0]    quot,
  output logic                          sat
);

  localparam int DW = scc_pkg::CUBE_W;
  localparam int QW = scc_pkg::QUOT_W;
  localparam int CW = DW + QW;

  logic [XW-1:0] r_q   [QW];
  logic [DW-1:0] d_q   [QW];
  logic [QW-1:0] q_q   [QW];
  logic          sat_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [XW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          sat_in;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rw;

    if (k == 0) begin : g_first
      assign r_in   = x;
      assign d_in   = d;
      assign q_in   = '0;
      assign sat_in = {{(DW-XW+QW){1'b0}}, x[XW-1:QW]} >= d;
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign d_in   = d_q[k-1];
      assign q_in   = q_q[k-1];
      assign sat_in = sat_q[k-1];
    end

    assign dsh = {{QW{1'b0}}, d_in} << I;
    assign rw  = {{(CW-XW){1'b0}}, r_in};

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[k]   <= d_in;
        sat_q[k] <= sat_in;
        if (rw >= dsh) begin
          r_q[k] <= XW'(rw - dsh);
          q_q[k] <= q_in | ({{(QW-1){1'b0}}, 1'b1} << I);
        end else begin
          r_q[k] <= r_in;
          q_q[k] <= q_in;
        end
      end
    end
  end

  assign quot = q_q[QW-1];
  assign sat  = sat_q[QW-1];

endmodule

@@ hdl/space_curve_curvature_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space curve curvature core
// Speed and curvature of a 3D curve from its first and second derivatives.
// ----------------------------------------------------------------------------
//   channel | direction | contents
//   s_*     | in        | f and g vectors, six signed fixed-point components
//   m_*     | out       | curvature and speed, degenerate and saturated flags
//   cfg_*   | in        | min_speed threshold write
//
// One beat enters per cycle while the pipeline is not stalled; results leave in order.
// The latency is set by the two root extractions and the divider, one bit per stage.
// Reset clears the valid bits and restores min_speed to 1.
// A stalled output holds its beat; the pipeline stops only when its last stage
// holds a result that cannot move into the output register.
// ----------------------------------------------------------------------------
module space_curve_curvature_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [191:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // curvature, speed
  output logic [63:0]   m_tdata,
  // degenerate, saturated
  output logic [1:0]    m_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  localparam int XW = scc_pkg::ROOT_W + 2 * FRAC_BITS;

  logic [scc_pkg::MINS_W-1:0]   min_speed;
  logic [scc_pkg::PIPE_LAT-1:0] vld;
  logic                          en;
  logic                          out_load;

  logic [scc_pkg::NORM_W-1:0]       norm;
  logic [2:0][scc_pkg::CMAG_W-1:0]  cmag;
  logic [scc_pkg::SUMSQ_W-1:0]      sumsq;
  logic [scc_pkg::SPEED_W-1:0]      speed;
  logic [scc_pkg::SPEED_W-1:0]      speed_d;
  logic [scc_pkg::CUBE_W-1:0]       cube;
  logic [scc_pkg::CUBE_W-1:0]       cube_d;
  logic [scc_pkg::ROOT_W-1:0]       root;
  logic [scc_pkg::QUOT_W-1:0]       quot;
  logic                             div_sat;

  logic        degen;
  logic [31:0] curv_next;
  logic        sat_next;

  logic [31:0] curv_q;
  logic [31:0] speed_q;
  logic        degen_q;
  logic        sat_q;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed <= 16'd1;
    end else if (cfg_valid) begin
      min_speed <= cfg_data;
    end
  end

  assign out_load = !m_tvalid || m_tready;
  assign en       = out_load || !vld[scc_pkg::PIPE_LAT-1];
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[scc_pkg::PIPE_LAT-2:0], s_tvalid};
    end
  end

  scc_front u_front (
    .clk  (clk),
    .en   (en),
    .fx   (s_tdata[31:0]),
    .fy   (s_tdata[63:32]),
    .fz   (s_tdata[95:64]),
    .gx   (s_tdata[127:96]),
    .gy   (s_tdata[159:128]),
    .gz   (s_tdata[191:160]),
    .norm (norm),
    .cmag (cmag)
  );

  scc_isqrt #(.W(scc_pkg::NORM_W)) u_sqrt_speed (
    .clk  (clk),
    .en   (en),
    .x    (norm),
    .root (speed)
  );

  scc_cube u_cube (
    .clk   (clk),
    .en    (en),
    .speed (speed),
    .cube  (cube)
  );

  scc_delay #(.W(scc_pkg::CUBE_W), .DEPTH(scc_pkg::DLY_CUBE)) u_dly_cube (
    .clk (clk),
    .en  (en),
    .d   (cube),
    .q   (cube_d)
  );

  scc_delay #(.W(scc_pkg::SPEED_W), .DEPTH(scc_pkg::DLY_SPEED)) u_dly_speed (
    .clk (clk),
    .en  (en),
    .d   (speed),
    .q   (speed_d)
  );

  scc_sqsum u_sqsum (
    .clk   (clk),
    .en    (en),
    .cmag  (cmag),
    .sumsq (sumsq)
  );

  scc_isqrt #(.W(scc_pkg::SUMSQ_W)) u_sqrt_cross (
    .clk  (clk),
    .en   (en),
    .x    (sumsq),
    .root (root)
  );

  scc_div #(.XW(XW)) u_div (
    .clk  (clk),
    .en   (en),
    .x    ({root, {(2 * FRAC_BITS){1'b0}}}),
    .d    (cube_d),
    .quot (quot),
    .sat  (div_sat)
  );

  always_comb begin
    degen = (speed_d == '0) || (speed_d < {16'b0, min_speed});
    if (degen) begin
      curv_next = '0;
      sat_next  = 1'b0;
    end else if (div_sat) begin
      curv_next = '1;
      sat_next  = 1'b1;
    end else begin
      curv_next = quot;
      sat_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= vld[scc_pkg::PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      curv_q  <= curv_next;
      speed_q <= speed_d;
      degen_q <= degen;
      sat_q   <= sat_next;
    end
  end

  assign m_tdata = {speed_q, curv_q};
  assign m_tuser = {sat_q, degen_q};

endmodule

@@ hdl/scc_checker.sv @@
`timescale 1ns / 1ps
`include "space_curve_curvature_core_defines.svh"
// ----------------------------------------------------------------------------
// Space curve curvature port checker
// Checks result flag consistency and output hold on the top-level ports.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [63:0]   m_tdata,
  input logic [1:0]    m_tuser
);

  `SCC_CHECK_NOW(a_flags_exclusive, m_tvalid, !(m_tuser[0] && m_tuser[1]), "both flags set")
  `SCC_CHECK_NOW(a_degen_zero, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0, "degenerate curvature not zero")
  `SCC_CHECK_NOW(a_sat_max, m_tvalid && m_tuser[1], m_tdata[31:0] == 32'hFFFFFFFF, "saturated curvature not max")
  `SCC_CHECK_NOW(a_zero_speed, m_tvalid && (m_tdata[63:32] == 32'd0), m_tuser[0], "zero speed not degenerate")
  `SCC_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

endmodule

bind space_curve_curvature_core scc_checker u_scc_checker (.*);

@@ dv/space_curve_curvature_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space curve curvature checker
// Watches the input, output and threshold channels of the curvature core.
// Each accepted input beat is turned into an expected speed, curvature and
// flag set by exact wide integer arithmetic. Each output beat is compared with
// the oldest expectation. Mismatches are reported one line each and counted.
// ----------------------------------------------------------------------------
module space_curve_curvature_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] curvature;
    logic [31:0] speed;
    logic        degenerate;
    logic        saturated;
  } curve_result_t;

  curve_result_t expected_curves[$];
  logic [15:0]   speed_floor;

  function automatic logic [63:0] int_sqrt(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic curve_result_t curvature_of(input logic [191:0] d,
                                                 input logic [15:0] floor_q);
    logic signed [127:0] fx, fy, fz, gx, gy, gz;
    logic [127:0] ax, ay, az, norm_sq, cross_sq, num, den, quot;
    logic [63:0]  spd, mag;
    curve_result_t r;
    fx = $signed(d[31:0]);
    fy = $signed(d[63:32]);
    fz = $signed(d[95:64]);
    gx = $signed(d[127:96]);
    gy = $signed(d[159:128]);
    gz = $signed(d[191:160]);
    norm_sq = fx * fx + fy * fy + fz * fz;
    spd = int_sqrt(norm_sq);
    r = '0;
    r.speed = spd[31:0];
    if (spd == 0 || spd < {48'd0, floor_q}) begin
      r.degenerate = 1'b1;
    end else begin
      ax = abs_wide(fy * gz - fz * gy);
      ay = abs_wide(fz * gx - fx * gz);
      az = abs_wide(fx * gy - fy * gx);
      cross_sq = ax * ax + ay * ay + az * az;
      mag = int_sqrt(cross_sq);
      num = {32'd0, mag, 32'd0};
      den = {64'd0, spd} * {64'd0, spd} * {64'd0, spd};
      quot = num / den;
      if (quot[127:32] != 0) begin
        r.curvature = 32'hFFFF_FFFF;
        r.saturated = 1'b1;
      end else begin
        r.curvature = quot[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_curves.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    curve_result_t want;
    if (rst) begin
      speed_floor <= 16'd1;
      expected_curves.delete();
    end else begin
      if (cfg_valid && cfg_ready) speed_floor <= cfg_data;
      if (s_tvalid && s_tready) expected_curves.push_back(curvature_of(s_tdata, speed_floor));
      if (m_tvalid && m_tready) begin
        if (expected_curves.size() == 0) begin
          $display("%0t: output beat with no expectation, data %h", $realtime, m_tdata);
          fail_count++;
        end else begin
          want = expected_curves.pop_front();
          if (m_tdata[31:0] !== want.curvature)
            report_mismatch("curvature", m_tdata[31:0], want.curvature);
          if (m_tdata[63:32] !== want.speed)
            report_mismatch("speed", m_tdata[63:32], want.speed);
          if (m_tuser[0] !== want.degenerate)
            report_mismatch("degenerate", {31'd0, m_tuser[0]}, {31'd0, want.degenerate});
          if (m_tuser[1] !== want.saturated)
            report_mismatch("saturated", {31'd0, m_tuser[1]}, {31'd0, want.saturated});
        end
      end
    end
  end

endmodule

@@ dv/space_curve_curvature_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space curve curvature core testbench
// Drives derivative beats and threshold writes into the core with random
// gaps and output stalls, including one long output hold-off, and leaves
// all checking to the checker. Prints the verdict once everything drains.
// ----------------------------------------------------------------------------
module space_curve_curvature_core_tb;

  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 3000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // first_x, first_y, first_z, second_x, second_y, second_z
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // curvature, speed
  logic [63:0]  m_tdata;
  // degenerate, saturated
  logic [1:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           beats_sent;
  int           idle_cycles;

  space_curve_curvature_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  space_curve_curvature_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [31:0] random_component();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return v;
      2, 3: return $signed(v) >>> $urandom_range(1, 31);
      4: return $signed(v) >>> $urandom_range(12, 20);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'd0;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input logic [191:0] d);
    logic taken;
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  task automatic send_with_gap(input logic [191:0] d);
    int gap;
    send_beat(d);
    gap = gap_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_speed_floor(input logic [15:0] value);
    logic taken;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [191:0] pack_vectors(input logic [31:0] fx, fy, fz, gx, gy, gz);
    return {gz, gy, gx, fz, fy, fx};
  endfunction

  task automatic random_phase(input int count);
    repeat (count) begin
      send_with_gap(pack_vectors(random_component(), random_component(),
                                 random_component(), random_component(),
                                 random_component(), random_component()));
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off that
  // backs the pipeline up into the input.
  initial begin
    int mode_left;
    int hold_done;
    int stall_pct;
    m_tready  = 1'b0;
    hold_done = 0;
    mode_left = 0;
    stall_pct = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && beats_sent >= 150) begin
        hold_done = 1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      end
      mode_left--;
      if ($urandom_range(0, 199) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(15, 60)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    beats_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset threshold.
    send_with_gap(pack_vectors(0, 0, 0, 32'h0001_0000, 0, 0));
    send_with_gap(pack_vectors(1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_with_gap(pack_vectors(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0));
    send_with_gap(pack_vectors(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0));
    send_with_gap(pack_vectors(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_with_gap(pack_vectors(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_with_gap(pack_vectors(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 0, 32'h0000_0001));
    send_with_gap(pack_vectors(32'h7FFF_FFFF, 32'h8000_0000, 0,
                               0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_with_gap(pack_vectors(32'h0003_0000, 32'hFFFC_0000, 0,
                               32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000));
    random_phase(400);
    pause_until_drained();

    write_speed_floor(16'd0);
    send_with_gap(pack_vectors(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    send_with_gap(pack_vectors(1, 0, 0, 0, 1, 0));
    random_phase(380);
    pause_until_drained();

    write_speed_floor(16'hFFFF);
    send_with_gap(pack_vectors(32'd65534, 0, 0, 0, 32'h0001_0000, 0));
    send_with_gap(pack_vectors(32'd65535, 0, 0, 0, 32'h0001_0000, 0));
    send_with_gap(pack_vectors(0, 32'd65536, 0, 32'h0001_0000, 0, 32'h0001_0000));
    random_phase(400);
    pause_until_drained();

    write_speed_floor(16'($urandom_range(2, 65534)));
    random_phase(230);
    pause_until_drained();

    write_speed_floor(16'd1);
    random_phase(230);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
